[hw/rtl/ltp_pkg.sv]
// Package for the lottery task picker: sizes, result codes, microcode ROM.
// Used by lottery_task_picker_unit; no dependencies.
package ltp_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int ID_W        = 8;
  localparam int TK_W        = 8;
  localparam int NICE_W      = 6;
  localparam int RND_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int MAX_TICKETS = 205;

  localparam int ENTRY_W = ID_W + TK_W;
  localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  // Holds the ticket total and the divisor total + 1.
  localparam int SUM_W   = $clog2(MAX_TASKS * MAX_TICKETS + 2);
  localparam int BIT_W   = $clog2(RND_W + 1);

  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic [ID_W-1:0] ID_FIRST = 8'd1;
  localparam logic [ID_W-1:0] ID_LAST  = 8'd255;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FETCH,
    OP_ADD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RD_POS,
    OP_WALK,
    OP_RD_NEXT,
    OP_WR_SHIFT,
    OP_GRANT,
    OP_EMPTY
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_DRAW,
    C_POOL_EMPTY,
    C_DIV_MORE,
    C_WALK_MORE,
    C_SHIFT_DONE
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  emit;    // step writes the result register
  } ctl_t;

  localparam upc_t UPC_FETCH    = 4'd0;
  localparam upc_t UPC_DISPATCH = 4'd1;
  localparam upc_t UPC_ADD      = 4'd2;
  localparam upc_t UPC_DRAW     = 4'd3;
  localparam upc_t UPC_DIV      = 4'd4;
  localparam upc_t UPC_WALK_RD  = 4'd5;
  localparam upc_t UPC_WALK     = 4'd6;
  localparam upc_t UPC_SHIFT_RD = 4'd7;
  localparam upc_t UPC_SHIFT_WR = 4'd8;
  localparam upc_t UPC_GRANT    = 4'd9;
  localparam upc_t UPC_EMPTY    = 4'd10;

  // Microcode ROM. Taken jump goes to target, otherwise to the next step.
  function automatic ctl_t ucode(input upc_t upc);
    ctl_t c;
    c = '{op: OP_NONE, cond: C_ALWAYS, target: UPC_FETCH, emit: 1'b0};
    case (upc)
      UPC_FETCH:    c = '{op: OP_FETCH,    cond: C_NO_INPUT,   target: UPC_FETCH,
                          emit: 1'b0};
      UPC_DISPATCH: c = '{op: OP_NONE,     cond: C_IS_DRAW,    target: UPC_DRAW,
                          emit: 1'b0};
      UPC_ADD:      c = '{op: OP_ADD,      cond: C_ALWAYS,     target: UPC_FETCH,
                          emit: 1'b1};
      UPC_DRAW:     c = '{op: OP_DIV_INIT, cond: C_POOL_EMPTY, target: UPC_EMPTY,
                          emit: 1'b0};
      UPC_DIV:      c = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: UPC_DIV,
                          emit: 1'b0};
      UPC_WALK_RD:  c = '{op: OP_RD_POS,   cond: C_NEVER,      target: UPC_FETCH,
                          emit: 1'b0};
      UPC_WALK:     c = '{op: OP_WALK,     cond: C_WALK_MORE,  target: UPC_WALK_RD,
                          emit: 1'b0};
      UPC_SHIFT_RD: c = '{op: OP_RD_NEXT,  cond: C_SHIFT_DONE, target: UPC_GRANT,
                          emit: 1'b0};
      UPC_SHIFT_WR: c = '{op: OP_WR_SHIFT, cond: C_ALWAYS,     target: UPC_SHIFT_RD,
                          emit: 1'b0};
      UPC_GRANT:    c = '{op: OP_GRANT,    cond: C_ALWAYS,     target: UPC_FETCH,
                          emit: 1'b1};
      UPC_EMPTY:    c = '{op: OP_EMPTY,    cond: C_ALWAYS,     target: UPC_FETCH,
                          emit: 1'b1};
      default:      c = '{op: OP_NONE,     cond: C_ALWAYS,     target: UPC_FETCH,
                          emit: 1'b0};
    endcase
    return c;
  endfunction

  // 105 - 5*nice, nice clamped to -20..20.
  function automatic logic [TK_W-1:0] nice_to_tickets(input logic signed [NICE_W-1:0] nice);
    logic signed [NICE_W-1:0] n;
    logic signed [9:0]        t;
    n = nice;
    if (nice < -6'sd20) n = -6'sd20;
    if (nice > 6'sd20)  n = 6'sd20;
    t = 10'sd105 - 10'(n) * 10'sd5;
    return t[TK_W-1:0];
  endfunction

endpackage

[hw/rtl/ltp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lottery_task_picker_unit.sv]
// Lottery task picker: add requests join a pool, draws grant one task by lottery.
// Add: fetch, dispatch, then the add step writes the result. Draw: bit-serial modulo,
//   walk from the newest pool entry, close-up, grant; an empty pool gives ST_EMPTY.
// Throughput: one transaction in flight; in_stall is high outside the fetch step.
// Reset: synchronous rst_n clears pool count, ticket total, sequencer, out_valid;
//   next id is 1. Depends on ltp_pkg and ltp_ram.
module lottery_task_picker_unit
  import ltp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic signed [NICE_W-1:0]   in_nice_value,
  input  logic [RND_W-1:0]           in_random_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [ID_W-1:0]            out_task_id,
  output logic [TK_W-1:0]            out_task_tickets
);

  // Sequencer state
  upc_t upc_r, upc_nxt;
  ctl_t ctl;

  // Captured request
  logic                     req_r, req_nxt;
  logic signed [NICE_W-1:0] nice_r, nice_nxt;

  // Pool bookkeeping. total_r tracks the ticket sum so draws need no summing pass.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic [ID_W-1:0]  next_id_r, next_id_nxt;

  // Bit-serial modulo: dvd_r shifts out the random value MSB first.
  logic [RND_W-1:0] dvd_r, dvd_nxt;
  logic [SUM_W-1:0] div_r, div_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;   // winning number once the modulo finishes
  logic [BIT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [SUM_W:0]   rem_sh;

  // Walk position, then close-up index
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_plus1;

  // Granted task
  logic [ID_W-1:0] gid_r, gid_nxt;
  logic [TK_W-1:0] gtk_r, gtk_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [TK_W-1:0]     otk_r, otk_nxt;

  // Pool RAM: entry = {id, tickets}; slot 0 oldest, slot count-1 newest.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0]    rd_id;
  logic [TK_W-1:0]    rd_tk;

  logic [TK_W-1:0] add_tk;
  logic            pool_full;
  logic            out_free;
  logic            hold;
  logic            walk_more;
  logic            cond_hit;

  ltp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ctl       = ucode(upc_r);
  assign rd_id     = ram_rdata[ENTRY_W-1:TK_W];
  assign rd_tk     = ram_rdata[TK_W-1:0];
  assign add_tk    = nice_to_tickets(nice_r);
  assign pool_full = (count_r >= CNT_W'(MAX_TASKS));
  assign idx_plus1 = idx_r + 1'b1;
  assign rem_sh    = {rem_r, dvd_r[RND_W-1]};

  // Result slot frees up when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // An emitting step waits for the slot; the datapath op is suppressed meanwhile.
  assign hold     = ctl.emit && !out_free;

  // Walk goes on while the tickets are below the remaining number, down to slot 0.
  assign walk_more = (SUM_W'(rd_tk) < rem_r) && (idx_r != '0);

  assign in_stall = (ctl.op != OP_FETCH);

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_task_id      = oid_r;
  assign out_task_tickets = otk_r;

  // Jump condition select
  always_comb begin
    case (ctl.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_NO_INPUT:   cond_hit = !in_valid;
      C_IS_DRAW:    cond_hit = req_r;
      C_POOL_EMPTY: cond_hit = (count_r == '0);
      C_DIV_MORE:   cond_hit = (bitcnt_r != BIT_W'(1));
      C_WALK_MORE:  cond_hit = walk_more;
      C_SHIFT_DONE: cond_hit = (idx_plus1 >= count_r);
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_nxt = upc_r;
    end else if (cond_hit) begin
      upc_nxt = ctl.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  // Datapath
  always_comb begin
    req_nxt     = req_r;
    nice_nxt    = nice_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    next_id_nxt = next_id_r;
    dvd_nxt     = dvd_r;
    div_nxt     = div_r;
    rem_nxt     = rem_r;
    bitcnt_nxt  = bitcnt_r;
    idx_nxt     = idx_r;
    gid_nxt     = gid_r;
    gtk_nxt     = gtk_r;
    status_nxt  = status_r;
    oid_nxt     = oid_r;
    otk_nxt     = otk_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_r[IDX_W-1:0];

    out_valid_nxt = out_valid_r && out_stall;

    if (!hold) begin
      case (ctl.op)
        OP_FETCH: begin
          if (in_valid) begin
            req_nxt  = in_req_type;
            nice_nxt = in_nice_value;
            dvd_nxt  = in_random_value;
          end
        end
        OP_ADD: begin
          out_valid_nxt = 1'b1;
          if (pool_full) begin
            status_nxt = ST_FULL;
            oid_nxt    = '0;
            otk_nxt    = '0;
          end else begin
            ram_we      = 1'b1;
            ram_waddr   = count_r[IDX_W-1:0];
            ram_wdata   = {next_id_r, add_tk};
            count_nxt   = count_r + 1'b1;
            total_nxt   = total_r + SUM_W'(add_tk);
            status_nxt  = ST_ADDED;
            oid_nxt     = next_id_r;
            otk_nxt     = add_tk;
            // id zero stays reserved across the wrap
            next_id_nxt = (next_id_r == ID_LAST) ? ID_FIRST : next_id_r + 1'b1;
          end
        end
        OP_DIV_INIT: begin
          div_nxt    = total_r + 1'b1;
          rem_nxt    = '0;
          bitcnt_nxt = BIT_W'(RND_W);
          idx_nxt    = count_r - 1'b1;
        end
        OP_DIV_STEP: begin
          if (rem_sh >= {1'b0, div_r}) begin
            rem_nxt = SUM_W'(rem_sh - {1'b0, div_r});
          end else begin
            rem_nxt = rem_sh[SUM_W-1:0];
          end
          dvd_nxt    = {dvd_r[RND_W-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r - 1'b1;
        end
        OP_RD_POS: begin
          ram_raddr = idx_r[IDX_W-1:0];
        end
        OP_WALK: begin
          if (walk_more) begin
            rem_nxt = rem_r - SUM_W'(rd_tk);
            idx_nxt = idx_r - 1'b1;
          end else begin
            gid_nxt = rd_id;
            gtk_nxt = rd_tk;
          end
        end
        OP_RD_NEXT: begin
          ram_raddr = idx_plus1[IDX_W-1:0];
        end
        OP_WR_SHIFT: begin
          // close up: entry i+1 moves down to i
          ram_we    = 1'b1;
          ram_waddr = idx_r[IDX_W-1:0];
          ram_wdata = ram_rdata;
          idx_nxt   = idx_plus1;
        end
        OP_GRANT: begin
          out_valid_nxt = 1'b1;
          count_nxt     = count_r - 1'b1;
          total_nxt     = total_r - SUM_W'(gtk_r);
          status_nxt    = ST_GRANTED;
          oid_nxt       = gid_r;
          otk_nxt       = gtk_r;
        end
        OP_EMPTY: begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_EMPTY;
          oid_nxt       = '0;
          otk_nxt       = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_FETCH;
      count_r     <= '0;
      total_r     <= '0;
      next_id_r   <= ID_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    nice_r   <= nice_nxt;
    dvd_r    <= dvd_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    bitcnt_r <= bitcnt_nxt;
    idx_r    <= idx_nxt;
    gid_r    <= gid_nxt;
    gtk_r    <= gtk_nxt;
    status_r <= status_nxt;
    oid_r    <= oid_nxt;
    otk_r    <= otk_nxt;
  end

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("pool count above capacity");

  // Every task holds at least five tickets, so the total is zero exactly when empty.
  a_total_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (total_r == '0))
    else $error("ticket total out of step with pool count");

  a_grant_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_GRANTED) |-> (oid_r != '0 && otk_r >= TK_W'(5)))
    else $error("granted task has reserved id or too few tickets");

  a_grant_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_GRANT && !hold) |=> (count_r == $past(count_r) - 1'b1))
    else $error("grant did not remove one task");

endmodule
